// ===== rtl/htsu_pkg.sv =====
// ----------------------------------------------------------------------------
// htsu_pkg
// Shared widths, codes and beat types of the hysteresis threshold sensor.
// ----------------------------------------------------------------------------
`default_nettype none

package htsu_pkg;

  localparam int USAGE_BITS = 48;
  localparam int COUNT_BITS = 32;
  localparam int CFG_IDX_BITS = 2;
  localparam int CFG_DATA_BITS = USAGE_BITS;

  // request codes
  localparam logic FUNC_SAMPLE  = 1'b0;
  localparam logic FUNC_DELIVER = 1'b1;

  // delivered event codes
  localparam logic [1:0] EV_NONE    = 2'd0;
  localparam logic [1:0] EV_TRIGGER = 2'd1;
  localparam logic [1:0] EV_CLEAR   = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_BITS-1:0] CFG_HIGH_LIMIT    = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_LOW_THRESHOLD = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_COUNTER_MODE  = 2'd2;

  typedef struct packed {
    logic                  func;
    logic [USAGE_BITS-1:0] used_amount;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]            event_kind;
    logic [COUNT_BITS-1:0] event_count;
    logic [USAGE_BITS-1:0] event_usage;
    logic                  is_on;
    logic [COUNT_BITS-1:0] trigger_total;
    logic [COUNT_BITS-1:0] triggers_waiting;
    logic [COUNT_BITS-1:0] clears_waiting;
  } out_beat_t;

  typedef struct packed {
    logic [USAGE_BITS-1:0] high_limit;
    logic [USAGE_BITS-1:0] low_threshold;
    logic                  counter_mode;
  } cfg_t;

endpackage

`default_nettype wire

// ===== rtl/htsu_cfg.sv =====
// ----------------------------------------------------------------------------
// htsu_cfg
// Configuration register file: thresholds and mode, written by index.
// ----------------------------------------------------------------------------
`default_nettype none

module htsu_cfg (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               cfg_we,
  input  wire logic [htsu_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  wire logic [htsu_pkg::CFG_DATA_BITS-1:0] cfg_wdata,
  output htsu_pkg::cfg_t                          cfg
);

  htsu_pkg::cfg_t cfg_r;
  htsu_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        htsu_pkg::CFG_HIGH_LIMIT:
          cfg_nxt.high_limit = cfg_wdata[htsu_pkg::USAGE_BITS-1:0];
        htsu_pkg::CFG_LOW_THRESHOLD:
          cfg_nxt.low_threshold = cfg_wdata[htsu_pkg::USAGE_BITS-1:0];
        htsu_pkg::CFG_COUNTER_MODE:
          cfg_nxt.counter_mode = cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

// ===== rtl/htsu_core.sv =====
// ----------------------------------------------------------------------------
// htsu_core
// Sensor state and its update step for one sample or deliver beat.
// ----------------------------------------------------------------------------
`default_nettype none

module htsu_core (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 step_en,
  input  wire htsu_pkg::in_beat_t   beat,
  input  wire htsu_pkg::cfg_t       cfg,
  output htsu_pkg::out_beat_t       result
);

  localparam logic [htsu_pkg::COUNT_BITS-1:0] CNT_MAX = '1;

  logic                            on_r, on_nxt;
  logic [htsu_pkg::COUNT_BITS-1:0] total_r, total_nxt;
  logic [htsu_pkg::COUNT_BITS-1:0] ptrig_r, ptrig_nxt;
  logic [htsu_pkg::COUNT_BITS-1:0] pclr_r, pclr_nxt;
  logic [htsu_pkg::USAGE_BITS-1:0] latch_r, latch_nxt;

  logic                            over_high;
  logic                            below_low;
  logic                            active;
  logic                            take_trig;
  logic                            take_clr;
  logic [htsu_pkg::COUNT_BITS:0]   total_sum;
  logic [1:0]                      kind;
  logic [htsu_pkg::COUNT_BITS-1:0] count;

  always_comb begin
    over_high = beat.used_amount >= cfg.high_limit;
    below_low = (cfg.low_threshold != '0) && (beat.used_amount < cfg.low_threshold);
    active    = on_r || (ptrig_r != '0);
    // gauge mode only re-arms after a clear is pending
    take_trig = over_high &&
                (cfg.counter_mode || (!on_r && ptrig_r == '0) || pclr_r != '0);
    take_clr  = !take_trig && below_low && active &&
                (cfg.counter_mode || pclr_r == '0);
    total_sum = {1'b0, total_r} + {1'b0, ptrig_r};

    on_nxt    = on_r;
    total_nxt = total_r;
    ptrig_nxt = ptrig_r;
    pclr_nxt  = pclr_r;
    latch_nxt = latch_r;
    kind      = htsu_pkg::EV_NONE;
    count     = '0;

    if (beat.func == htsu_pkg::FUNC_SAMPLE) begin
      if (cfg.high_limit != '0) begin
        if (take_trig) begin
          ptrig_nxt = (ptrig_r == CNT_MAX) ? ptrig_r : ptrig_r + 1'b1;
          latch_nxt = beat.used_amount;
          pclr_nxt  = '0;
        end else if (take_clr) begin
          pclr_nxt = (pclr_r == CNT_MAX) ? pclr_r : pclr_r + 1'b1;
        end
      end
    end else if (ptrig_r != '0 || pclr_r != '0) begin
      count = ptrig_r;
      if (pclr_r != '0) begin
        kind     = htsu_pkg::EV_CLEAR;
        on_nxt   = 1'b0;
        pclr_nxt = '0;
      end else begin
        kind      = htsu_pkg::EV_TRIGGER;
        on_nxt    = 1'b1;
        total_nxt = total_sum[htsu_pkg::COUNT_BITS] ? CNT_MAX
                                                    : total_sum[htsu_pkg::COUNT_BITS-1:0];
      end
      ptrig_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      on_r    <= 1'b0;
      total_r <= '0;
      ptrig_r <= '0;
      pclr_r  <= '0;
      latch_r <= '0;
    end else if (step_en) begin
      on_r    <= on_nxt;
      total_r <= total_nxt;
      ptrig_r <= ptrig_nxt;
      pclr_r  <= pclr_nxt;
      latch_r <= latch_nxt;
    end
  end

  always_comb begin
    result.event_kind       = kind;
    result.event_count      = count;
    result.event_usage      = latch_nxt;
    result.is_on            = on_nxt;
    result.trigger_total    = total_nxt;
    result.triggers_waiting = ptrig_nxt;
    result.clears_waiting   = pclr_nxt;
  end

endmodule

`default_nettype wire

// ===== rtl/hysteresis_threshold_sensor_unit.sv =====
// a beat accepted into the input register shows its result on out_data once the result register takes it
// throughput: one beat per cycle while out_stall is low; input register, one update step, result register
// in_stall rises only while both registers hold beats and out_stall is high
// reset (rst_n low, synchronous) clears thresholds, mode, sensor state and valids
// ----------------------------------------------------------------------------
// hysteresis_threshold_sensor_unit
// Hysteresis threshold sensor: samples queue triggers or clears, deliver
// beats hand them over as one event.
// ----------------------------------------------------------------------------
`default_nettype none

module hysteresis_threshold_sensor_unit (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output      logic                               in_stall,
  input  wire htsu_pkg::in_beat_t                 in_data,
  output      logic                               out_valid,
  input  wire logic                               out_stall,
  output htsu_pkg::out_beat_t                     out_data,
  input  wire logic                               cfg_we,
  input  wire logic [htsu_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  wire logic [htsu_pkg::CFG_DATA_BITS-1:0] cfg_wdata
);

  htsu_pkg::cfg_t      cfg;
  htsu_pkg::in_beat_t  in_beat_r;
  logic                in_vld_r;
  htsu_pkg::out_beat_t result;
  htsu_pkg::out_beat_t out_beat_r;
  logic                out_vld_r;
  logic                advance;
  logic                step_en;

  htsu_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // result register free or draining this cycle
  assign advance  = !out_vld_r || !out_stall;
  assign step_en  = in_vld_r && advance;
  assign in_stall = in_vld_r && !advance;

  htsu_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (step_en),
    .beat    (in_beat_r),
    .cfg     (cfg),
    .result  (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (!in_stall) begin
        in_vld_r <= in_valid;
      end
      if (advance) begin
        out_vld_r <= in_vld_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      in_beat_r <= in_data;
    end
    if (step_en) begin
      out_beat_r <= result;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_beat_r;

endmodule

`default_nettype wire
